// ----- src/btsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barrel thread accounting package
// Shared types, constants and helper functions of the round-robin thread
// issuer with cycle and miss-stall accounting.
// ----------------------------------------------------------------------------
package btsa_pkg;

  localparam int unsigned MAX_THREADS = 16;
  localparam int unsigned COUNT_BITS  = 48;
  localparam int unsigned TID_BITS    = $clog2(MAX_THREADS);
  localparam int unsigned TC_BITS     = 5;
  localparam int unsigned SEED_BITS   = 32;
  localparam int unsigned HASH_BITS   = 32;

  localparam logic [TC_BITS-1:0] TC_RESET   = TC_BITS'(4);
  localparam logic [SEED_BITS-1:0] SEED_RESET = SEED_BITS'(42);

  localparam logic [HASH_BITS-1:0] TAG_MUL  = HASH_BITS'(31);
  localparam logic [HASH_BITS-1:0] J_MUL    = HASH_BITS'(131);
  localparam logic [HASH_BITS-1:0] K_MUL    = HASH_BITS'(197);
  localparam logic [HASH_BITS-1:0] ACT_MUL  = HASH_BITS'(7);
  localparam logic [HASH_BITS-1:0] HASH_MUL = HASH_BITS'(1274126177);

  // Reciprocal of the modulus, exact for every 32-bit dividend.
  localparam int unsigned RECIP_SHIFT = 41;
  localparam logic [HASH_BITS-1:0] RECIP_MUL = HASH_BITS'(64'd2199023256);
  localparam int unsigned QUOT_BITS = 2 * HASH_BITS - RECIP_SHIFT;
  localparam logic [HASH_BITS-1:0] MOD_BASE = HASH_BITS'(1000);
  localparam int unsigned REM_BITS = 10;

  localparam logic [REM_BITS-1:0] LIMIT_ACT = REM_BITS'(6);
  localparam logic [REM_BITS-1:0] LIMIT_DOT = REM_BITS'(24);
  localparam logic [COUNT_BITS-1:0] STALL_LAT_ACT = COUNT_BITS'(3);
  localparam logic [COUNT_BITS-1:0] STALL_LAT_DOT = COUNT_BITS'(8);

  localparam logic [0:0] CFG_THREAD_COUNT = 1'd0;
  localparam logic [0:0] CFG_STALL_SEED   = 1'd1;

  typedef enum logic [2:0] {
    MODE_ISSUE   = 3'd0,
    MODE_YIELD   = 3'd1,
    MODE_BEGIN   = 3'd2,
    MODE_END     = 3'd3,
    MODE_UNTIMED = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_TURN   = 2'd1,
    STATUS_CLOSED = 2'd2
  } status_e;

  typedef struct packed {
    mode_e               mode;
    logic [TID_BITS-1:0] tid;
    logic                heavy;
    logic                act;
  } ctl_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [7:0]  tag;
    logic [15:0] idx_j;
    logic [15:0] idx_k;
  } item_t;

  // Number of threads in rotation: zero acts as one, large values clamp.
  function automatic logic [TC_BITS-1:0] live_threads(input logic [TC_BITS-1:0] tc);
    logic [TC_BITS-1:0] n;
    n = tc;
    if (n == '0) begin
      n = TC_BITS'(1);
    end else if (n > TC_BITS'(MAX_THREADS)) begin
      n = TC_BITS'(MAX_THREADS);
    end
    return n;
  endfunction

  // Five-step restoring remainder of a narrow value.
  function automatic logic [TID_BITS-1:0] narrow_mod(input logic [TC_BITS-1:0] a,
                                                     input logic [TC_BITS-1:0] n);
    logic [TC_BITS-1:0] rem;
    rem = '0;
    for (int i = TC_BITS - 1; i >= 0; i--) begin
      rem = {rem[TC_BITS-2:0], a[i]};
      if (rem >= n) begin
        rem = rem - n;
      end
    end
    return rem[TID_BITS-1:0];
  endfunction

  function automatic logic [HASH_BITS-1:0] hash_premix(input logic [SEED_BITS-1:0] seed,
                                                       input logic [7:0] tag,
                                                       input logic [15:0] j,
                                                       input logic [15:0] k,
                                                       input logic act);
    logic [HASH_BITS-1:0] x;
    x = seed;
    x = x ^ (HASH_BITS'(tag) * TAG_MUL);
    x = x ^ (HASH_BITS'(j) * J_MUL);
    x = x ^ (HASH_BITS'(k) * K_MUL);
    x = x ^ (HASH_BITS'(act) * ACT_MUL);
    x = x ^ (x >> 13);
    return x;
  endfunction

endpackage

// ----- src/barrel_thread_turn_and_stall_accounting.sv -----
`timescale 1ns / 1ps
// An event passes registers a, b, c, d and the output register in turn.
// Throughput: one event per cycle while m_axis_tready is high; the miss
// hash runs in three pipeline stages ahead of the one state-update stage.
// Reset: counters, clock, turn and resume clocks are zero, no phase is open,
// thread_count is 4 and the miss seed is 42.
// ----------------------------------------------------------------------------
// Barrel thread turn and stall accounting
// Round-robin thread issuer that tracks the cycle clock, per-thread resume
// clocks, miss stalls and operation counters for a stream of events.
// ----------------------------------------------------------------------------
module barrel_thread_turn_and_stall_accounting (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tid[3:0], heavy[4], act[5], tag[13:6],
  // idx_j[29:14], idx_k[45:30], zero fill [47:46]
  input  logic [47:0]   s_axis_tdata,
  // mode[2:0]
  input  logic [2:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // stalled[0], cycle_clock[48:1], turn_now[52:49], light_ops[100:53],
  // heavy_ops[148:101], stall_events[196:149], switch_events[244:197],
  // untimed_ops[292:245], zero fill [295:293]
  output logic [295:0]  m_axis_tdata,
  // status[1:0]
  output logic [1:0]    m_axis_tuser,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [0:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  localparam int unsigned CB = btsa_pkg::COUNT_BITS;
  localparam int unsigned TB = btsa_pkg::TID_BITS;
  localparam int unsigned HB = btsa_pkg::HASH_BITS;
  localparam int unsigned QB = btsa_pkg::QUOT_BITS;
  localparam int unsigned RB = btsa_pkg::REM_BITS;
  localparam int unsigned NT = btsa_pkg::MAX_THREADS;

  logic [btsa_pkg::TC_BITS-1:0]   tc_q;
  logic [btsa_pkg::SEED_BITS-1:0] seed_q;

  logic a_v_q, b_v_q, c_v_q, d_v_q, o_v_q;
  logic a_rdy, b_rdy, c_rdy, d_rdy, o_rdy, d_fire;

  btsa_pkg::item_t a_q;
  btsa_pkg::ctl_t  b_ctl_q, c_ctl_q, d_ctl_q;
  logic [HB-1:0]   b_x_q, c_h_q;
  logic [QB-1:0]   c_quot_q;
  logic            d_hit_q;

  logic [HB-1:0]   b_x_d, c_h_d;
  logic [2*HB-1:0] recip_prod;
  logic [HB-1:0]   quot_scaled, rem_full;
  logic [RB-1:0]   rem;
  logic            d_hit_d;

  logic [CB-1:0] clock_q, clock_d;
  logic [TB-1:0] turn_q, turn_d;
  logic          phase_q, phase_d;
  logic [CB-1:0] resume_q [NT];
  logic [CB-1:0] resume_d [NT];
  logic [CB-1:0] light_q, light_d, heavy_q, heavy_d, stall_q, stall_d;
  logic [CB-1:0] switch_q, switch_d, untimed_q, untimed_d;

  btsa_pkg::status_e status_d;
  logic              stalled_d;
  logic [btsa_pkg::TC_BITS-1:0] n_live;
  logic [CB-1:0]     base_clk, issue_clk, resume_sel;

  btsa_pkg::status_e o_status_q;
  logic              o_stalled_q;
  logic [CB-1:0]     o_clock_q, o_light_q, o_heavy_q, o_stall_q, o_switch_q, o_untimed_q;
  logic [TB-1:0]     o_turn_q;

  assign o_rdy  = !o_v_q || m_axis_tready;
  assign d_rdy  = !d_v_q || o_rdy;
  assign c_rdy  = !c_v_q || d_rdy;
  assign b_rdy  = !b_v_q || c_rdy;
  assign a_rdy  = !a_v_q || b_rdy;
  assign d_fire = d_v_q && o_rdy;

  assign s_axis_tready = a_rdy;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q   <= btsa_pkg::TC_RESET;
      seed_q <= btsa_pkg::SEED_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        btsa_pkg::CFG_THREAD_COUNT: tc_q <= cfg_data_i[btsa_pkg::TC_BITS-1:0];
        btsa_pkg::CFG_STALL_SEED:   seed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= s_axis_tvalid;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
      if (d_rdy) d_v_q <= c_v_q;
      if (o_rdy) o_v_q <= d_v_q;
    end
  end

  assign b_x_d      = btsa_pkg::hash_premix(seed_q, a_q.tag, a_q.idx_j, a_q.idx_k, a_q.ctl.act)
                      * btsa_pkg::HASH_MUL;
  assign c_h_d      = b_x_q ^ (b_x_q >> 16);
  assign recip_prod = {{HB{1'b0}}, c_h_d} * {{HB{1'b0}}, btsa_pkg::RECIP_MUL};
  assign quot_scaled = HB'({{(HB-QB){1'b0}}, c_quot_q} * btsa_pkg::MOD_BASE);
  assign rem_full   = c_h_q - quot_scaled;
  assign rem        = rem_full[RB-1:0];
  assign d_hit_d    = c_ctl_q.act ? (rem < btsa_pkg::LIMIT_ACT) : (rem < btsa_pkg::LIMIT_DOT);

  always_ff @(posedge clk_i) begin
    if (a_rdy && s_axis_tvalid) begin
      a_q.ctl.mode  <= btsa_pkg::mode_e'(s_axis_tuser);
      a_q.ctl.tid   <= s_axis_tdata[3:0];
      a_q.ctl.heavy <= s_axis_tdata[4];
      a_q.ctl.act   <= s_axis_tdata[5];
      a_q.tag       <= s_axis_tdata[13:6];
      a_q.idx_j     <= s_axis_tdata[29:14];
      a_q.idx_k     <= s_axis_tdata[45:30];
    end
    if (b_rdy && a_v_q) begin
      b_ctl_q <= a_q.ctl;
      b_x_q   <= b_x_d;
    end
    if (c_rdy && b_v_q) begin
      c_ctl_q  <= b_ctl_q;
      c_h_q    <= c_h_d;
      c_quot_q <= recip_prod[2*HB-1:btsa_pkg::RECIP_SHIFT];
    end
    if (d_rdy && c_v_q) begin
      d_ctl_q <= c_ctl_q;
      d_hit_q <= d_hit_d;
    end
  end

  assign n_live     = btsa_pkg::live_threads(tc_q);
  assign resume_sel = resume_q[d_ctl_q.tid];
  assign base_clk   = (clock_q < resume_sel) ? resume_sel : clock_q;
  assign issue_clk  = base_clk + ((n_live > btsa_pkg::TC_BITS'(1)) ?
                      (d_ctl_q.heavy ? (d_ctl_q.act ? CB'(3) : CB'(4)) : CB'(2)) : CB'(1));

  always_comb begin
    clock_d   = clock_q;
    turn_d    = turn_q;
    phase_d   = phase_q;
    resume_d  = resume_q;
    light_d   = light_q;
    heavy_d   = heavy_q;
    stall_d   = stall_q;
    switch_d  = switch_q;
    untimed_d = untimed_q;
    status_d  = btsa_pkg::STATUS_OK;
    stalled_d = 1'b0;
    case (d_ctl_q.mode)
      btsa_pkg::MODE_ISSUE, btsa_pkg::MODE_YIELD: begin
        if (!phase_q) begin
          status_d = btsa_pkg::STATUS_CLOSED;
        end else if (d_ctl_q.tid != turn_q) begin
          status_d = btsa_pkg::STATUS_TURN;
        end else begin
          turn_d = btsa_pkg::narrow_mod(btsa_pkg::TC_BITS'(turn_q) + btsa_pkg::TC_BITS'(1),
                                        n_live);
          if (d_ctl_q.mode == btsa_pkg::MODE_ISSUE) begin
            clock_d = issue_clk;
            if (d_ctl_q.heavy) begin
              heavy_d = heavy_q + CB'(1);
            end else begin
              light_d = light_q + CB'(1);
            end
            if (n_live > btsa_pkg::TC_BITS'(1)) begin
              switch_d = switch_q + CB'(1);
            end
            if (d_hit_q) begin
              stalled_d = 1'b1;
              stall_d   = stall_q + CB'(1);
              resume_d[d_ctl_q.tid] = issue_clk + (d_ctl_q.act ? btsa_pkg::STALL_LAT_ACT
                                                               : btsa_pkg::STALL_LAT_DOT);
            end
          end else begin
            clock_d = base_clk;
          end
        end
      end
      btsa_pkg::MODE_BEGIN: begin
        phase_d = 1'b1;
        turn_d  = '0;
        for (int i = 0; i < NT; i++) begin
          resume_d[i] = '0;
        end
      end
      btsa_pkg::MODE_END: begin
        phase_d = 1'b0;
      end
      btsa_pkg::MODE_UNTIMED: begin
        untimed_d = untimed_q + CB'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q   <= '0;
      turn_q    <= '0;
      phase_q   <= 1'b0;
      light_q   <= '0;
      heavy_q   <= '0;
      stall_q   <= '0;
      switch_q  <= '0;
      untimed_q <= '0;
      for (int i = 0; i < NT; i++) begin
        resume_q[i] <= '0;
      end
    end else if (d_fire) begin
      clock_q   <= clock_d;
      turn_q    <= turn_d;
      phase_q   <= phase_d;
      light_q   <= light_d;
      heavy_q   <= heavy_d;
      stall_q   <= stall_d;
      switch_q  <= switch_d;
      untimed_q <= untimed_d;
      resume_q  <= resume_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_fire) begin
      o_status_q  <= status_d;
      o_stalled_q <= stalled_d;
      o_clock_q   <= clock_d;
      o_turn_q    <= turn_d;
      o_light_q   <= light_d;
      o_heavy_q   <= heavy_d;
      o_stall_q   <= stall_d;
      o_switch_q  <= switch_d;
      o_untimed_q <= untimed_d;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tuser  = o_status_q;
  assign m_axis_tdata  = {3'b000, o_untimed_q, o_switch_q, o_stall_q, o_heavy_q, o_light_q,
                          o_turn_q, o_clock_q, o_stalled_q};

`ifndef NO_ASSERTIONS
  a_stall_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != btsa_pkg::STATUS_OK)) |-> !m_axis_tdata[0])
    else $error("stall reported on an event that was not accepted");

  a_closed_phase_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_fire && !phase_q && ((d_ctl_q.mode == btsa_pkg::MODE_ISSUE) ||
                            (d_ctl_q.mode == btsa_pkg::MODE_YIELD)))
    |=> ($stable(clock_q) && $stable(turn_q) && $stable(stall_q)))
    else $error("issue or yield changed state while the phase was closed");

  a_begin_resets_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_fire && (d_ctl_q.mode == btsa_pkg::MODE_BEGIN)) |=> (phase_q && (turn_q == '0)))
    else $error("begin phase did not open the phase at thread zero");

  a_stall_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_fire && stalled_d) |=> (stall_q == $past(stall_q) + CB'(1)))
    else $error("miss stall did not advance the stall counter by one");
`endif

endmodule
